[hdl/smp_pkg.sv]
// shared types, command codes and frame helpers for the serial mouse port
// no dependencies; used by smp_core and serial_mouse_port
package smp_pkg;

    localparam int unsigned DELTA_W   = 8;
    localparam int unsigned BUTTON_W  = 3;
    localparam int unsigned PORT_W    = 8;
    localparam int unsigned ACCUM_W   = 16;
    localparam int unsigned FRAME_W   = 9;
    localparam int unsigned QUEUE_W   = 3 * FRAME_W;
    localparam int unsigned COUNT_W   = 5;

    localparam logic [7:0] STATUS_BASE  = 8'h40;
    localparam logic [7:0] STATUS_LEFT  = 8'h20;
    localparam logic [7:0] STATUS_RIGHT = 8'h10;
    localparam logic [7:0] LOW6_MASK    = 8'h3F;
    localparam logic signed [ACCUM_W-1:0] SAT_MAX = 16'sd127;
    localparam logic signed [ACCUM_W-1:0] SAT_MIN = -16'sd127;

    localparam logic [COUNT_W-1:0] QUEUE_FULL = COUNT_W'(QUEUE_W);

    localparam int unsigned PORT_STROBE = 0;
    localparam int unsigned PORT_MODE   = 2;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } smp_cmd_t;

    typedef struct packed {
        logic [1:0]                 command;
        logic signed [DELTA_W-1:0]  delta_x;
        logic signed [DELTA_W-1:0]  delta_y;
        logic [BUTTON_W-1:0]        button_bits;
        logic [PORT_W-1:0]          port_value;
    } smp_item_t;

    // clamp a signed accumulator to -127..127, returned as a byte
    function automatic logic [7:0] sat127(input logic signed [ACCUM_W-1:0] acc);
        logic signed [ACCUM_W-1:0] v;
        v = acc;
        if (acc > SAT_MAX) v = SAT_MAX;
        if (acc < SAT_MIN) v = SAT_MIN;
        return v[7:0];
    endfunction

    // start bit 0 first, then data bits 6..0, then stop bit 1
    function automatic logic [FRAME_W-1:0] make_frame(input logic [7:0] data);
        logic [FRAME_W-1:0] f;
        f = '0;
        for (int i = 0; i < 7; i++) begin
            f[i+1] = data[6-i];
        end
        f[FRAME_W-1] = 1'b1;
        return f;
    endfunction

endpackage

[hdl/smp_core.sv]
// mouse state, accumulators and serial shift queue for the serial mouse port
// depends on smp_pkg; one item is applied per cycle when step is high
module smp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  smp_pkg::smp_item_t  item,
    output logic                read_bit
);

    logic [smp_pkg::PORT_W-1:0]   port_latch_reg, port_latch_next;
    logic [smp_pkg::QUEUE_W-1:0]  pending_bits_reg, pending_bits_next;
    logic [smp_pkg::COUNT_W-1:0]  pending_count_reg, pending_count_next;
    logic [smp_pkg::DELTA_W-1:0]  last_dx_reg, last_dx_next;
    logic [smp_pkg::DELTA_W-1:0]  last_dy_reg, last_dy_next;
    logic [smp_pkg::BUTTON_W-1:0] held_buttons_reg, held_buttons_next;
    logic [smp_pkg::ACCUM_W-1:0]  accum_x_reg, accum_x_next;
    logic [smp_pkg::ACCUM_W-1:0]  accum_y_reg, accum_y_next;

    logic [7:0] ax8, ay8, status;
    logic       rising;

    assign ax8 = smp_pkg::sat127(signed'(accum_x_reg));
    assign ay8 = smp_pkg::sat127(signed'(accum_y_reg));

    assign status = smp_pkg::STATUS_BASE
                  | (held_buttons_reg[0] ? smp_pkg::STATUS_LEFT  : 8'h00)
                  | (held_buttons_reg[1] ? smp_pkg::STATUS_RIGHT : 8'h00)
                  | {4'b0000, ax8[7:6], ay8[7:6]};

    // strobe goes low to high with serial mode selected
    assign rising = !item.port_value[smp_pkg::PORT_MODE]
                  && !port_latch_reg[smp_pkg::PORT_STROBE]
                  && item.port_value[smp_pkg::PORT_STROBE];

    always_comb begin
        port_latch_next    = port_latch_reg;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        last_dx_next       = last_dx_reg;
        last_dy_next       = last_dy_reg;
        held_buttons_next  = held_buttons_reg;
        accum_x_next       = accum_x_reg;
        accum_y_next       = accum_y_reg;
        read_bit           = 1'b0;
        case (item.command)
            smp_pkg::CMD_FRAME: begin
                last_dx_next      = item.delta_x;
                last_dy_next      = item.delta_y;
                held_buttons_next = item.button_bits;
                accum_x_next = accum_x_reg + {{8{item.delta_x[7]}}, item.delta_x};
                accum_y_next = accum_y_reg + {{8{item.delta_y[7]}}, item.delta_y};
            end
            smp_pkg::CMD_WRITE: begin
                port_latch_next = item.port_value;
                if (rising) begin
                    if (pending_count_reg == '0) begin
                        pending_bits_next = {smp_pkg::make_frame(ax8 & smp_pkg::LOW6_MASK),
                                             smp_pkg::make_frame(ay8 & smp_pkg::LOW6_MASK),
                                             smp_pkg::make_frame(status)};
                        pending_count_next = smp_pkg::QUEUE_FULL;
                        accum_x_next = accum_x_reg - {{8{ax8[7]}}, ax8};
                        accum_y_next = accum_y_reg - {{8{ay8[7]}}, ay8};
                    end else begin
                        pending_bits_next  = pending_bits_reg >> 1;
                        pending_count_next = pending_count_reg - 1'b1;
                    end
                end
            end
            smp_pkg::CMD_READ: begin
                if (port_latch_reg[smp_pkg::PORT_MODE]) begin
                    read_bit = (held_buttons_reg != '0) || (last_dx_reg != '0)
                            || (last_dy_reg != '0);
                end else if (port_latch_reg[smp_pkg::PORT_STROBE]
                             && pending_count_reg != '0) begin
                    read_bit = !pending_bits_reg[0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_latch_reg    <= '0;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            last_dx_reg       <= '0;
            last_dy_reg       <= '0;
            held_buttons_reg  <= '0;
            accum_x_reg       <= '0;
            accum_y_reg       <= '0;
        end else if (step) begin
            port_latch_reg    <= port_latch_next;
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            last_dx_reg       <= last_dx_next;
            last_dy_reg       <= last_dy_next;
            held_buttons_reg  <= held_buttons_next;
            accum_x_reg       <= accum_x_next;
            accum_y_reg       <= accum_y_next;
        end
    end

endmodule

[hdl/serial_mouse_port.sv]
// serial mouse port: a stream of frame, port write and port read transactions
// in, one read_bit result per transaction out. depends on smp_pkg and smp_core
//
// usage: s_axis carries one item per transaction, command in tuser. frame items
// update deltas, buttons and the motion accumulators; port writes drive the
// strobe and mode bits and shift the serial queue; port reads return the data
// line. every item gives exactly one result on m_axis, zero for non-reads.
// an accepted item is held in an input register, where its state update and
// result are computed once the output can advance; the result then goes to the
// output register, shown on m_axis. throughput: one item per cycle while m_axis
// is not stalled; the input and output registers move together.
// m_axis_tready low holds the output register; the input register fills and
// then s_axis_tready drops. no state changes while an item is held.
// reset: aresetn low clears the valid flags of both stages and all mouse and queue state.
module serial_mouse_port (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // delta_x [7:0], delta_y [15:8], button_bits [18:16], port_value [26:19], zero [31:27]
    input  logic [31:0] s_axis_tdata,
    // command [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_bit [0], zero [7:1]
    output logic [7:0]  m_axis_tdata
);

    smp_pkg::smp_item_t item_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               out_bit_reg;
    logic               advance;
    logic               step;
    logic               read_bit;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg.command     <= s_axis_tuser;
            item_reg.delta_x     <= s_axis_tdata[7:0];
            item_reg.delta_y     <= s_axis_tdata[15:8];
            item_reg.button_bits <= s_axis_tdata[18:16];
            item_reg.port_value  <= s_axis_tdata[26:19];
        end
        if (step) begin
            out_bit_reg <= read_bit;
        end
    end

    smp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .item     (item_reg),
        .read_bit (read_bit)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_bit_reg};

endmodule

[tb/sv/tb_serial_mouse_port.sv]
`timescale 1ns / 1ps
// self-checking testbench for serial_mouse_port: stream stimulus, random idling
// depends on smp_pkg and serial_mouse_port from hdl/
module tb_serial_mouse_port;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [7:0] STROBE_MASK = 8'(1) << smp_pkg::PORT_STROBE;
    localparam logic [7:0] MODE_MASK   = 8'(1) << smp_pkg::PORT_MODE;
    localparam int RANDOM_END  = 1225;
    localparam int CALM_FROM   = 1075;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 8;

    // mirror of the mouse and its serial line, plus the read bits still owed
    class mouse_port_mirror;
        logic [7:0]                  port_latch;
        logic [smp_pkg::QUEUE_W-1:0] line_bits;
        logic [smp_pkg::COUNT_W-1:0] line_count;
        logic [7:0]                  last_dx;
        logic [7:0]                  last_dy;
        logic [2:0]                  buttons;
        logic [15:0]                 accum_x;
        logic [15:0]                 accum_y;
        logic                        read_bits_due[$];
        int                          errors;

        function new();
            port_latch = '0;
            line_bits  = '0;
            line_count = '0;
            last_dx    = '0;
            last_dy    = '0;
            buttons    = '0;
            accum_x    = '0;
            accum_y    = '0;
            errors     = 0;
        endfunction

        function logic [7:0] clamp_motion(input logic [15:0] acc);
            logic signed [15:0] v;
            v = acc;
            if (v > 16'sd127) return 8'h7F;
            if (v < -16'sd127) return 8'h81;
            return acc[7:0];
        endfunction

        // start bit in bit 0, data msb first, stop bit on top
        function logic [smp_pkg::FRAME_W-1:0] line_frame(input logic [7:0] b);
            return {1'b1, b[0], b[1], b[2], b[3], b[4], b[5], b[6], 1'b0};
        endfunction

        function void strobe_write(input logic [7:0] pv);
            logic [7:0] ax;
            logic [7:0] ay;
            logic [7:0] status;
            if (!pv[smp_pkg::PORT_MODE] && !port_latch[smp_pkg::PORT_STROBE]
                && pv[smp_pkg::PORT_STROBE]) begin
                if (line_count == 0) begin
                    ax = clamp_motion(accum_x);
                    ay = clamp_motion(accum_y);
                    status = smp_pkg::STATUS_BASE
                           | (buttons[0] ? smp_pkg::STATUS_LEFT : 8'h00)
                           | (buttons[1] ? smp_pkg::STATUS_RIGHT : 8'h00)
                           | {4'b0, ax[7:6], ay[7:6]};
                    line_bits = {line_frame(ax & smp_pkg::LOW6_MASK),
                                 line_frame(ay & smp_pkg::LOW6_MASK),
                                 line_frame(status)};
                    line_count = smp_pkg::QUEUE_FULL;
                    accum_x = accum_x - {{8{ax[7]}}, ax};
                    accum_y = accum_y - {{8{ay[7]}}, ay};
                end else begin
                    line_bits  = line_bits >> 1;
                    line_count = line_count - 1'b1;
                end
            end
            port_latch = pv;
        endfunction

        function logic data_line();
            if (port_latch[smp_pkg::PORT_MODE])
                return (buttons != 0) || (last_dx != 0) || (last_dy != 0);
            if (port_latch[smp_pkg::PORT_STROBE] && line_count != 0)
                return ~line_bits[0];
            return 1'b0;
        endfunction

        function void note_item(input logic [1:0] cmd, input logic [7:0] dx,
                                input logic [7:0] dy, input logic [2:0] btn,
                                input logic [7:0] pv);
            logic seen;
            seen = 1'b0;
            case (cmd)
                smp_pkg::CMD_FRAME: begin
                    last_dx = dx;
                    last_dy = dy;
                    buttons = btn;
                    accum_x = accum_x + {{8{dx[7]}}, dx};
                    accum_y = accum_y + {{8{dy[7]}}, dy};
                end
                smp_pkg::CMD_WRITE: strobe_write(pv);
                smp_pkg::CMD_READ:  seen = data_line();
                default:   seen = 1'b0;
            endcase
            read_bits_due.push_back(seen);
        endfunction

        function void check_read_bit(input logic actual);
            logic due;
            if (read_bits_due.size() == 0) begin
                $error("read_bit: unexpected transaction, actual %0b", actual);
                errors++;
            end else begin
                due = read_bits_due.pop_front();
                if (due !== actual) begin
                    $error("read_bit: expected %0b, actual %0b", due, actual);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return read_bits_due.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    mouse_port_mirror mirror = new();
    int  items_sent = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;

    serial_mouse_port dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 aclk = ~aclk;

    // sink side: random stall bursts until the calm tail of the run
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                mirror.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tdata[18:16], s_axis_tdata[26:19]);
            if (m_axis_tvalid && m_axis_tready)
                mirror.check_read_bit(m_axis_tdata[0]);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] dx,
                             input logic [7:0] dy, input logic [2:0] btn,
                             input logic [7:0] pv);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, pv, btn, dy, dx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
        calm = (items_sent >= CALM_FROM);
        @(negedge aclk);
    endtask

    // unused fields of each transaction carry random bits
    task automatic post_motion(input logic [7:0] dx, input logic [7:0] dy,
                               input logic [2:0] btn);
        send_item(smp_pkg::CMD_FRAME, dx, dy, btn, 8'($urandom));
    endtask

    task automatic write_port(input logic [7:0] pv);
        send_item(smp_pkg::CMD_WRITE, 8'($urandom), 8'($urandom), 3'($urandom), pv);
    endtask

    task automatic read_port();
        send_item(smp_pkg::CMD_READ, 8'($urandom), 8'($urandom), 3'($urandom),
                  8'($urandom));
    endtask

    // host clocking bits out: strobe low, strobe high, sample the line
    task automatic poll_mouse(input int edges);
        repeat (edges) begin
            write_port(8'($urandom) & ~(STROBE_MASK | MODE_MASK));
            if ($urandom_range(0, 7) == 0) read_port();
            write_port((8'($urandom) & ~MODE_MASK) | STROBE_MASK);
            read_port();
            if ($urandom_range(0, 11) == 0)
                post_motion(8'($urandom), 8'($urandom), 3'($urandom));
        end
    endtask

    initial begin
        logic [7:0] big;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = smp_pkg::CMD_FRAME;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset state, presence, saturation, frame load and shifting
        read_port();
        write_port(MODE_MASK);
        read_port();
        post_motion(8'h7F, 8'h80, 3'b111);
        read_port();
        post_motion(8'h7F, 8'h80, 3'b000);
        write_port(8'h00);
        write_port(STROBE_MASK);
        read_port();
        write_port(STROBE_MASK);
        read_port();
        write_port(8'h00);
        write_port(STROBE_MASK | MODE_MASK);
        read_port();
        write_port(8'h00);
        write_port(8'hFB);
        read_port();
        write_port(8'hFA);
        read_port();
        send_item(CMD_UNUSED, 8'h80, 8'h7F, 3'b101, 8'hFF);
        post_motion(8'h00, 8'h00, 3'b000);
        write_port(MODE_MASK);
        read_port();

        while (items_sent < RANDOM_END) begin
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 4))
                    post_motion(8'($urandom), 8'($urandom), 3'($urandom));
                2: begin
                    // push the accumulators past the clamp
                    big = $urandom_range(0, 1) ? 8'($urandom_range(100, 127))
                                               : 8'($urandom_range(128, 156));
                    repeat ($urandom_range(2, 6))
                        post_motion(big, ~big, 3'($urandom));
                end
                3, 4, 5, 6: poll_mouse($urandom_range(1, 28));
                7: write_port(8'($urandom));
                8: begin
                    if ($urandom_range(0, 1) == 0) write_port(8'($urandom) | MODE_MASK);
                    read_port();
                end
                default: send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 3'($urandom),
                                   8'($urandom));
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (mirror.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mirror.errors == 0 && mirror.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/smp_pkg.sv
hdl/smp_core.sv
hdl/serial_mouse_port.sv
tb/sv/tb_serial_mouse_port.sv
